>>> rtl/core/cpsp_pkg.sv
// Shared types, codes and constants for the CAN power supply poller.
package cpsp_pkg;

  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned IdWidth     = 29;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned PayWidth    = 64;
  localparam int unsigned AddrWidth   = 4;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_OFFLINE = 3'd1,
    ST_WAIT    = 3'd2
  } seq_state_t;

  // Item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_FRAME  = 2'd2;

  // Reply register codes (byte 3 of a module reply)
  localparam logic [7:0] RREG_STATUS = 8'h40;
  localparam logic [7:0] RREG_VOLT   = 8'h01;
  localparam logic [7:0] RREG_CURR   = 8'h02;
  localparam logic [7:0] RREG_TEMP   = 8'h04;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLL_PERIOD = 2'd0;
  localparam logic [1:0] CFG_COMMAND_ID  = 2'd1;
  localparam logic [1:0] CFG_REPLY_ID    = 2'd2;

  localparam logic [PeriodWidth-1:0] POLL_PERIOD_RESET = 16'd2000;
  localparam logic [IdWidth-1:0]     COMMAND_ID_RESET  = 29'h0608_0780;
  localparam logic [IdWidth-1:0]     REPLY_ID_RESET    = 29'h060F_8000;
  localparam logic [PeriodWidth-1:0] TICKS_MAX         = 16'hFFFF;

  // Transmit payloads, byte 0 in the top byte
  localparam logic [PayWidth-1:0] PAY_ON     = 64'h0300_0030_0000_0000;
  localparam logic [PayWidth-1:0] PAY_OFF    = 64'h0300_0030_0001_0000;
  localparam logic [PayWidth-1:0] PAY_STATUS = 64'h1000_0040_0000_0000;
  localparam logic [PayWidth-1:0] PAY_VOLT   = 64'h1000_0001_0000_0000;
  localparam logic [PayWidth-1:0] PAY_CURR   = 64'h1000_0002_0000_0000;
  localparam logic [PayWidth-1:0] PAY_TEMP   = 64'h1000_0004_0000_0000;

  typedef struct packed {
    logic [1:0]           kind;
    logic [IdWidth-1:0]   frame_id;
    logic [7:0]           reply_register;
    logic [WordWidth-1:0] reply_value;
  } item_t;

  typedef struct packed {
    logic [PeriodWidth-1:0] poll_period;
    logic [IdWidth-1:0]     command_id;
    logic [IdWidth-1:0]     reply_id;
  } cfg_t;

  typedef struct packed {
    seq_state_t             seq;
    logic [PeriodWidth-1:0] elapsed;
    logic                   enabled;
    logic [WordWidth-1:0]   last_word;
    logic [WordWidth-1:0]   voltage;
    logic [WordWidth-1:0]   current;
    logic [WordWidth-1:0]   temperature;
  } core_state_t;

  typedef struct packed {
    logic                tx_valid;
    logic [PayWidth-1:0] tx_payload;
  } tx_t;

endpackage

>>> rtl/core/cpsp_regs.sv
// APB configuration registers of the poller.
module cpsp_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpsp_pkg::AddrWidth-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output cpsp_pkg::cfg_t                   cfg
);
  import cpsp_pkg::*;

  logic       wr;
  logic [1:0] index;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign index  = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_period <= POLL_PERIOD_RESET;
      cfg.command_id  <= COMMAND_ID_RESET;
      cfg.reply_id    <= REPLY_ID_RESET;
    end else if (wr) begin
      unique case (index)
        CFG_POLL_PERIOD: cfg.poll_period <= pwdata[PeriodWidth-1:0];
        CFG_COMMAND_ID:  cfg.command_id  <= pwdata[IdWidth-1:0];
        CFG_REPLY_ID:    cfg.reply_id    <= pwdata[IdWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      CFG_POLL_PERIOD: prdata = {16'd0, cfg.poll_period};
      CFG_COMMAND_ID:  prdata = {3'd0, cfg.command_id};
      CFG_REPLY_ID:    prdata = {3'd0, cfg.reply_id};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/cpsp_step.sv
// Next-state and transmit logic for one poller item.
module cpsp_step (
  input  cpsp_pkg::item_t       item,
  input  cpsp_pkg::cfg_t        cfg,
  input  cpsp_pkg::core_state_t cur,
  output cpsp_pkg::core_state_t nxt,
  output cpsp_pkg::tx_t         tx
);
  import cpsp_pkg::*;

  logic [PeriodWidth-1:0] ticks_inc;
  logic                   poll_due;
  logic                   reply_ok;
  seq_state_t             seq_next;

  assign ticks_inc = (cur.elapsed != TICKS_MAX) ? cur.elapsed + 1'b1 : cur.elapsed;
  assign poll_due  = (cur.seq == ST_IDLE) && (ticks_inc >= cfg.poll_period);
  assign reply_ok  = (item.frame_id == cfg.reply_id) && (cur.seq == ST_WAIT);

  // Sequencer next state
  always_comb begin
    seq_next = cur.seq;
    unique case (item.kind)
      KIND_TICK:   if (poll_due) seq_next = ST_WAIT;
      KIND_BUTTON: seq_next = cur.enabled ? ST_OFFLINE : ST_IDLE;
      KIND_FRAME:  if (reply_ok && item.reply_register == RREG_TEMP) seq_next = ST_IDLE;
      default: ;
    endcase
  end

  // Data state and transmit frame
  always_comb begin
    nxt         = cur;
    nxt.seq     = seq_next;
    tx.tx_valid   = 1'b0;
    tx.tx_payload = '0;
    unique case (item.kind)
      KIND_TICK: begin
        nxt.elapsed = poll_due ? '0 : ticks_inc;
        if (poll_due) begin
          tx.tx_valid   = 1'b1;
          tx.tx_payload = PAY_STATUS;
        end
      end
      KIND_BUTTON: begin
        nxt.enabled   = !cur.enabled;
        tx.tx_valid   = 1'b1;
        tx.tx_payload = cur.enabled ? PAY_OFF : PAY_ON;
      end
      KIND_FRAME: begin
        nxt.last_word = item.reply_value;
        if (reply_ok) begin
          unique case (item.reply_register)
            RREG_STATUS: begin
              tx.tx_valid   = 1'b1;
              tx.tx_payload = PAY_VOLT;
            end
            RREG_VOLT: begin
              nxt.voltage   = item.reply_value;
              tx.tx_valid   = 1'b1;
              tx.tx_payload = PAY_CURR;
            end
            RREG_CURR: begin
              nxt.current   = item.reply_value;
              tx.tx_valid   = 1'b1;
              tx.tx_payload = PAY_TEMP;
            end
            RREG_TEMP: nxt.temperature = item.reply_value;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    // Offline: mirror the last data word into all readings
    if (seq_next == ST_OFFLINE) begin
      nxt.voltage     = nxt.last_word;
      nxt.current     = nxt.last_word;
      nxt.temperature = nxt.last_word;
    end
  end

endmodule

>>> rtl/core/can_power_supply_poller_top.sv
// Top level of the CAN power supply poller: item register, state, result register.
//
//  channel  signals                     beat taken when
//  in       in_valid / in_stall         in_valid && !in_stall
//  out      out_valid / out_stall       out_valid && !out_stall
//  cfg      APB psel/penable/pwrite     psel && penable && pwrite (pready tied high)
//
// An item is taken into the input register; when it advances, the step logic updates the
// poller state and loads the result register. One item per cycle is sustained while the
// output does not stall, set by the single step through the state registers.
// Reset (synchronous) empties both registers, puts the sequencer offline and clears
// readings and counters. A stalled output holds its beat; the input keeps accepting
// while the input register can drain into the result register.
module can_power_supply_poller_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         kind,
  input  logic [cpsp_pkg::IdWidth-1:0]       frame_id,
  input  logic [7:0]                         reply_register,
  input  logic [cpsp_pkg::WordWidth-1:0]     reply_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               tx_valid,
  output logic [cpsp_pkg::PayWidth-1:0]      tx_payload,
  output logic [cpsp_pkg::WordWidth-1:0]     voltage_bits,
  output logic [cpsp_pkg::WordWidth-1:0]     current_bits,
  output logic [cpsp_pkg::WordWidth-1:0]     temperature_bits,
  output logic [2:0]                         link_state,
  output logic                               output_enabled,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cpsp_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import cpsp_pkg::*;

  cfg_t        cfg;
  item_t       item;
  logic        in_full;
  logic        out_full;
  logic        advance;
  logic        in_take;
  core_state_t state;
  core_state_t state_next;
  tx_t         tx_next;

  cpsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpsp_step u_step (
    .item (item),
    .cfg  (cfg),
    .cur  (state),
    .nxt  (state_next),
    .tx   (tx_next)
  );

  assign advance  = in_full && (!out_full || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.kind           <= kind;
      item.frame_id       <= frame_id;
      item.reply_register <= reply_register;
      item.reply_value    <= reply_value;
    end
  end

  // Poller state advances once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      state.seq         <= ST_OFFLINE;
      state.elapsed     <= '0;
      state.enabled     <= 1'b0;
      state.last_word   <= '0;
      state.voltage     <= '0;
      state.current     <= '0;
      state.temperature <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_valid         <= tx_next.tx_valid;
      tx_payload       <= tx_next.tx_payload;
      voltage_bits     <= state_next.voltage;
      current_bits     <= state_next.current;
      temperature_bits <= state_next.temperature;
      link_state       <= state_next.seq;
      output_enabled   <= state_next.enabled;
    end
  end

  assign out_valid = out_full;

  a_no_payload_without_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_payload == '0)
    else $error("payload present without a transmit");

  a_offline_mirror: assert property (@(posedge clk) disable iff (rst)
    out_valid && link_state == ST_OFFLINE |->
      voltage_bits == current_bits && current_bits == temperature_bits)
    else $error("offline readings differ");

  a_disabled_offline: assert property (@(posedge clk) disable iff (rst)
    out_valid && !output_enabled |-> link_state == ST_OFFLINE)
    else $error("disabled but not offline");

  a_drain_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_full |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule
